// ===== hw/rtl/psm_pkg.sv =====
// psm_pkg: shared constants, opcodes and operator codes for the p-code step core
// no dependencies
package psm_pkg;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int CODE_DEPTH_DEF = 1024;
  localparam int MAX_LEVEL_DEF = 15;

  localparam logic [3:0] CMD_LIT = 4'd0;
  localparam logic [3:0] CMD_OPR = 4'd1;
  localparam logic [3:0] CMD_LOD = 4'd2;
  localparam logic [3:0] CMD_STO = 4'd3;
  localparam logic [3:0] CMD_CAL = 4'd4;
  localparam logic [3:0] CMD_INT = 4'd5;
  localparam logic [3:0] CMD_JMP = 4'd6;
  localparam logic [3:0] CMD_JPC = 4'd7;
  localparam logic [3:0] CMD_LAD = 4'd8;
  localparam logic [3:0] CMD_STA = 4'd9;

  localparam logic [4:0] OP_RET = 5'd0;
  localparam logic [4:0] OP_NEG = 5'd1;
  localparam logic [4:0] OP_ADD = 5'd2;
  localparam logic [4:0] OP_SUB = 5'd3;
  localparam logic [4:0] OP_MUL = 5'd4;
  localparam logic [4:0] OP_DIV = 5'd5;
  localparam logic [4:0] OP_ODD = 5'd6;
  localparam logic [4:0] OP_NOT = 5'd7;
  localparam logic [4:0] OP_EQ = 5'd8;
  localparam logic [4:0] OP_NE = 5'd9;
  localparam logic [4:0] OP_LT = 5'd10;
  localparam logic [4:0] OP_GE = 5'd11;
  localparam logic [4:0] OP_GT = 5'd12;
  localparam logic [4:0] OP_LE = 5'd13;
  localparam logic [4:0] OP_AND = 5'd14;
  localparam logic [4:0] OP_OR = 5'd15;
  localparam logic [4:0] OP_PRT = 5'd16;
  localparam logic [4:0] OP_NL = 5'd17;
  localparam logic [4:0] OP_RD = 5'd18;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_UNK = 2'd2;
  localparam logic [1:0] ERR_RANGE = 2'd3;

  // divider request and reply
  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

// ===== hw/rtl/pcode_stack_machine_step_core.sv =====
// pcode_stack_machine_step_core: executes one p-code instruction per transfer
// depends on psm_pkg, psm_div
//
// channel | direction | signals
// in      | receive   | in_valid, in_stall, command, level, operand, read_value
// out     | send      | out_valid, out_stall, next_pc, halted, print_valid,
//         |           |   print_value, newline, error_code
//
// sequencing: a small sequencer issues stack memory accesses one at a time; an
//   instruction does one extra read per static link walked, and a divide waits
//   on the separate divider; a new item is taken only once the sequencer is
//   idle again
// reset: pc 0, base 1, top 3; cells 1 to 3 are cleared by a sweep
// stalls: the result register holds while out_stall; the next item is taken
//   once the result register is free
module pcode_stack_machine_step_core #(
  parameter int STACK_DEPTH = psm_pkg::STACK_DEPTH_DEF,
  parameter int CODE_DEPTH = psm_pkg::CODE_DEPTH_DEF,
  parameter int MAX_LEVEL = psm_pkg::MAX_LEVEL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  command,
  input  logic [3:0]  level,
  input  logic signed [31:0] operand,
  input  logic signed [31:0] read_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  next_pc,
  output logic        halted,
  output logic        print_valid,
  output logic signed [31:0] print_value,
  output logic        newline,
  output logic [1:0]  error_code
);
  import psm_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(CODE_DEPTH);
  localparam int LW = $clog2(MAX_LEVEL + 1);

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD0 = 4'd2;   // issue first read
  localparam logic [3:0] S_RD0W = 4'd3;  // first read data
  localparam logic [3:0] S_RD1 = 4'd4;
  localparam logic [3:0] S_RD1W = 4'd5;
  localparam logic [3:0] S_WALK = 4'd6;
  localparam logic [3:0] S_WALKW = 4'd7;
  localparam logic [3:0] S_ARD = 4'd8;   // read at computed address
  localparam logic [3:0] S_ARDW = 4'd9;
  localparam logic [3:0] S_EXE = 4'd10;
  localparam logic [3:0] S_DIV = 4'd11;
  localparam logic [3:0] S_WR = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state;
  logic [1:0] clr_cnt;

  // architectural registers
  logic [SW-1:0] base;
  logic [SW-1:0] top;
  logic [CW-1:0] pc;

  // latched instruction
  logic [3:0]  cmd;
  logic [LW-1:0] lev_left;
  logic [31:0] opd;
  logic [31:0] rval;
  logic [4:0]  op;
  logic        op_known;

  // working values (wide signed addresses so range checks are exact)
  logic signed [33:0] t;
  logic signed [33:0] wbase;
  logic [31:0] x;
  logic [31:0] y;
  logic [1:0]  err;
  logic [CW-1:0] pcn;
  logic [31:0] pv;
  logic        pvalid;
  logic        nl;
  logic        wr_en;
  logic signed [33:0] wr_addr;
  logic [31:0] wr_data;
  logic [1:0]  wcnt;  // call frame writes

  // stack memory
  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata;
  logic        rd_ok;
  logic signed [33:0] raddr;
  logic        mem_we;
  logic [SW-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic        rd_ok_q;
  logic [31:0] rd_q;
  logic [31:0] x_top;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[raddr[SW-1:0]];
  end

  function automatic logic in_rng(input logic signed [33:0] a);
    in_rng = (a >= 0) && (a < 34'(STACK_DEPTH));
  endfunction

  // divider
  div_req_t dreq;
  div_rsp_t drsp;
  psm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_stall = (state != S_IDLE) || out_valid;

  logic signed [33:0] sx_x;
  assign sx_x = 34'(signed'(x));

  // shared result unit
  logic [31:0] alu;
  always_comb begin
    case (op)
      OP_ADD: alu = x + y;
      OP_SUB: alu = x - y;
      OP_MUL: alu = x * y;
      OP_EQ: alu = {31'd0, x == y};
      OP_NE: alu = {31'd0, x != y};
      OP_LT: alu = {31'd0, $signed(x) < $signed(y)};
      OP_GE: alu = {31'd0, $signed(x) >= $signed(y)};
      OP_GT: alu = {31'd0, $signed(x) > $signed(y)};
      OP_LE: alu = {31'd0, $signed(x) <= $signed(y)};
      OP_AND: alu = x & y;
      OP_OR: alu = x | y;
      OP_NEG: alu = 32'd0 - x;
      OP_ODD: alu = (x[0] ? (x[31] ? 32'hFFFF_FFFF : 32'd1) : 32'd0);
      OP_NOT: alu = {31'd0, x == 32'd0};
      default: alu = x;
    endcase
  end

  // read address per state
  logic signed [33:0] a_rd0, a_rd1, a_comp;
  always_comb begin
    a_rd0 = t;
    a_rd1 = t;
    unique case (cmd)
      CMD_OPR: begin
        if (op == OP_RET) begin
          a_rd0 = 34'(base) + 34'sd2;
          a_rd1 = 34'(base) + 34'sd1;
        end else if (op == OP_NEG || op == OP_ODD || op == OP_NOT || op == OP_PRT) begin
          a_rd0 = t;
          a_rd1 = t + 34'sd1;
        end else begin
          // binary operators: left operand sits below the top
          a_rd0 = t - 34'sd1;
          a_rd1 = t + 34'sd1;
        end
      end
      CMD_STA: a_rd0 = t - 34'sd1;
      default: a_rd0 = t;
    endcase
    a_comp = wbase + 34'(signed'(opd));
    if (cmd == CMD_LAD || cmd == CMD_STA) a_comp = a_comp + sx_x;
  end

  always_comb begin
    raddr = t;
    unique case (state)
      S_RD0: raddr = a_rd0;
      S_RD1: raddr = a_rd1;
      S_WALK: raddr = wbase;
      S_ARD: raddr = a_comp;
      default: raddr = t;
    endcase
    rd_ok = in_rng(raddr);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr[SW-1:0];
    mem_wd = wr_data;
    if (state == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = SW'(clr_cnt) + SW'(1);
      mem_wd = 32'd0;
    end else if (state == S_WR && wr_en && in_rng(wr_addr)) begin
      mem_we = 1'b1;
    end
  end

  logic [1:0] err_rd;
  assign err_rd = (err == ERR_NONE && !rd_ok) ? ERR_RANGE : err;

  // instruction sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= 2'd0;
      base <= SW'(1);
      top <= SW'(3);
      pc <= '0;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 2'd1;
          if (clr_cnt == 2'd2) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd <= command;
            lev_left <= (level > 4'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : LW'(level);
            opd <= operand;
            rval <= read_value;
            op <= operand[4:0];
            op_known <= (operand[31:5] == 27'd0) && (operand[4:0] <= OP_RD);
            t <= 34'(top);
            wbase <= 34'(base);
            pcn <= pc + CW'(1);
            err <= ERR_NONE;
            pv <= 32'd0;
            pvalid <= 1'b0;
            nl <= 1'b0;
            wr_en <= 1'b0;
            wcnt <= 2'd0;
            x <= 32'd0;
            state <= S_RD0;
          end
        end
        S_RD0: begin
          // dispatch; most commands need the top-of-stack read
          unique case (cmd)
            CMD_LIT: begin
              wr_en <= 1'b1; wr_addr <= t + 34'sd1; wr_data <= opd;
              t <= t + 34'sd1; state <= S_WR;
            end
            CMD_INT: begin
              t <= t + 34'(signed'(opd)); state <= S_DONE;
            end
            CMD_JMP: begin
              pcn <= opd[CW-1:0]; state <= S_DONE;
            end
            CMD_LOD, CMD_CAL: state <= (lev_left != 0) ? S_WALK : S_ARD;
            CMD_OPR: begin
              if (!op_known) begin
                err <= ERR_UNK; state <= S_DONE;
              end else if (op == OP_NL) begin
                nl <= 1'b1; state <= S_DONE;
              end else if (op == OP_RD) begin
                wr_en <= 1'b1; wr_addr <= t + 34'sd1; wr_data <= rval;
                t <= t + 34'sd1; state <= S_WR;
              end else begin
                if (op != OP_RET && op != OP_NEG && op != OP_ODD && op != OP_NOT
                    && op != OP_PRT) t <= t - 34'sd1;
                state <= S_RD0W;
                err <= err_rd;
              end
            end
            CMD_STO, CMD_JPC, CMD_LAD, CMD_STA: begin
              err <= err_rd; state <= S_RD0W;
            end
            default: begin
              err <= ERR_UNK; state <= S_DONE;
            end
          endcase
        end
        S_RD0W: begin
          x <= rd_q;
          unique case (cmd)
            CMD_OPR: begin
              if (op == OP_RET || (op >= OP_ADD && op <= OP_OR && op != OP_ODD
                  && op != OP_NOT)) state <= S_RD1;
              else state <= S_EXE;
            end
            CMD_JPC: state <= S_EXE;
            CMD_STA: state <= S_RD1;
            default: state <= (lev_left != 0) ? S_WALK : S_ARD;
          endcase
        end
        S_RD1: begin
          err <= err_rd; state <= S_RD1W;
        end
        S_RD1W: begin
          y <= rd_q;
          if (cmd == CMD_STA) state <= (lev_left != 0) ? S_WALK : S_ARD;
          else state <= S_EXE;
        end
        S_WALK: begin
          err <= err_rd; state <= S_WALKW;
        end
        S_WALKW: begin
          wbase <= 34'(signed'(rd_q));
          lev_left <= lev_left - LW'(1);
          state <= (lev_left == LW'(1)) ? ((cmd == CMD_CAL) ? S_EXE : S_ARD) : S_WALK;
        end
        S_ARD: begin
          if (cmd == CMD_CAL) begin
            state <= S_EXE;
          end else if (cmd == CMD_STO || cmd == CMD_STA) begin
            // store address; the value was read before the walk
            wr_addr <= a_comp; state <= S_EXE;
          end else begin
            err <= err_rd; state <= S_ARDW;
          end
        end
        S_ARDW: begin
          x <= rd_q; state <= S_EXE;
        end
        S_EXE: begin
          unique case (cmd)
            CMD_LOD: begin
              wr_en <= 1'b1; wr_addr <= t + 34'sd1; wr_data <= x;
              t <= t + 34'sd1; state <= S_WR;
            end
            CMD_LAD: begin
              wr_en <= 1'b1; wr_addr <= t; wr_data <= x; state <= S_WR;
            end
            CMD_STO: begin
              // x_top holds top of stack from first read
              wr_en <= 1'b1; wr_data <= x_top; t <= t - 34'sd1; state <= S_WR;
            end
            CMD_STA: begin
              // y holds top of stack from second read
              wr_en <= 1'b1; wr_data <= y; t <= t - 34'sd2; state <= S_WR;
            end
            CMD_JPC: begin
              if (x == 32'd0) pcn <= opd[CW-1:0];
              t <= t - 34'sd1; state <= S_DONE;
            end
            CMD_CAL: begin
              wr_en <= 1'b1; wr_addr <= t + 34'sd1; wr_data <= wbase[31:0];
              state <= S_WR;
            end
            default: begin
              // operator
              if (op == OP_RET) begin
                t <= 34'(base) - 34'sd1;
                pcn <= x[CW-1:0];
                base <= y[SW-1:0];
                state <= S_DONE;
              end else if (op == OP_PRT) begin
                pv <= x; pvalid <= 1'b1; t <= t - 34'sd1; state <= S_DONE;
              end else if (op == OP_DIV) begin
                if (err != ERR_NONE) state <= S_DONE;
                else if (y == 32'd0) begin
                  err <= ERR_DIV0; state <= S_DONE;
                end else begin
                  dreq.start <= 1'b1; state <= S_DIV;
                end
              end else begin
                wr_en <= 1'b1; wr_addr <= t; wr_data <= alu; state <= S_WR;
              end
            end
          endcase
        end
        S_DIV: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            wr_en <= 1'b1; wr_addr <= t; wr_data <= drsp.quotient; state <= S_WR;
          end
        end
        S_WR: begin
          if (!in_rng(wr_addr) && err == ERR_NONE) err <= ERR_RANGE;
          if (cmd == CMD_CAL && wcnt != 2'd2) begin
            wcnt <= wcnt + 2'd1;
            wr_addr <= wr_addr + 34'sd1;
            wr_data <= (wcnt == 2'd0) ? 32'(base) : 32'(pcn);
          end else begin
            if (cmd == CMD_CAL) begin
              base <= SW'(t + 34'sd1);
              pcn <= opd[CW-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            top <= t[SW-1:0];
            pc <= pcn;
            next_pc <= 10'(pcn);
            halted <= (pcn == '0);
            print_valid <= pvalid;
            print_value <= pv;
            newline <= nl;
            error_code <= err;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read data with out-of-range reads forced to zero
  always_ff @(posedge clk) rd_ok_q <= rd_ok;
  assign rd_q = rd_ok_q ? rdata : 32'd0;

  // top-of-stack value kept for stores
  always_ff @(posedge clk) begin
    if (state == S_RD0W) x_top <= rd_q;
  end

  assign dreq.dividend = x;
  assign dreq.divisor = y;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_halt_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (halted == (next_pc == 10'd0))) else $error("halt mismatch");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> (y != 32'd0)) else $error("divide by zero issued");
endmodule

// ===== hw/rtl/psm_div.sv =====
// psm_div: signed 32-bit divider, one quotient bit per cycle, truncating
// depends on psm_pkg
module psm_div (
  input  logic clk,
  input  logic rst,
  input  psm_pkg::div_req_t req,
  output psm_pkg::div_rsp_t rsp
);
  import psm_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  // restoring shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        rem <= 32'd0;
        quo <= req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
        dvs <= req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
        neg <= req.dividend[31] ^ req.divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  assign rsp.quotient = neg ? 32'd0 - quo : quo;
endmodule
